// ===== rtl/upq_pkg.sv =====
// ----------------------------------------------------------------------------
// upq_pkg: shared definitions for the unique priority queue
// Operation codes, default sizes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package upq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_PRIO_BITS   = 16;
  localparam int DEF_ELEM_BITS   = 16;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request fields
    logic step;    // remove one entry of the priority range
    logic finish;  // carry out the operation and register the result
  } upq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_op;   // the held request is a range removal
    logic range_hit;  // at least one held entry lies in the range
  } upq_sts_t;

endpackage

// ===== rtl/upq_ctrl.sv =====
// ----------------------------------------------------------------------------
// upq_ctrl: sequencing controller
// Accepts a request, then steps range removals one entry at a time and
// finishes every operation with a single result strobe.
// ----------------------------------------------------------------------------
module upq_ctrl
  import upq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  upq_sts_t sts,
  output upq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy = (state_r == ST_RUN);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.range_op && sts.range_hit) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/upq_datapath.sv =====
// ----------------------------------------------------------------------------
// upq_datapath: sorted slot array and result registers
// Slots are kept packed and in ascending priority; every slot compares itself
// with the request and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module upq_datapath
  import upq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int PRIO_BITS   = DEF_PRIO_BITS,
  parameter int ELEM_BITS   = DEF_ELEM_BITS,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1),
  parameter int IW          = $clog2(QUEUE_DEPTH)
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_op,
  input  logic [ELEM_BITS-1:0] in_element,
  input  logic [PRIO_BITS-1:0] in_priority_req,
  input  logic [PRIO_BITS-1:0] in_range_low,
  input  logic [PRIO_BITS-1:0] in_range_high,
  input  upq_cmd_t             cmd,
  output upq_sts_t             sts,
  output logic                 out_valid,
  output logic                 out_op_ok,
  output logic [ELEM_BITS-1:0] out_element,
  output logic [CW-1:0]        out_entry_count,
  output logic                 out_queue_empty
);

  // Held request.
  op_t                  op_r;
  logic [ELEM_BITS-1:0] elem_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [PRIO_BITS-1:0] lo_r;
  logic [PRIO_BITS-1:0] hi_r;
  logic                 removed_r;
  logic                 removed_nxt;

  // Queue state.
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [PRIO_BITS-1:0] slot_prio_r [QUEUE_DEPTH];
  logic [ELEM_BITS-1:0] slot_elem_r [QUEUE_DEPTH];

  // Result registers.
  logic                 out_valid_r;
  logic                 out_op_ok_r;
  logic [ELEM_BITS-1:0] out_element_r;
  logic [CW-1:0]        out_entry_count_r;
  logic                 out_queue_empty_r;

  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [QUEUE_DEPTH-1:0] dup_hit;
  logic [QUEUE_DEPTH-1:0] ins;
  logic [QUEUE_DEPTH-1:0] take_new;
  logic [QUEUE_DEPTH-1:0] at_lo;
  logic [QUEUE_DEPTH-1:0] rng_hit;

  logic                 full;
  logic                 enq_do;
  logic                 deq_do;
  logic [IW-1:0]        deq_idx;
  logic [CW-1:0]        count_dec;
  logic                 op_ok;
  logic [ELEM_BITS-1:0] res_elem;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
      logic [PRIO_BITS-1:0] prev_prio;
      logic [ELEM_BITS-1:0] prev_elem;
      logic [PRIO_BITS-1:0] next_prio;
      logic [ELEM_BITS-1:0] next_elem;

      assign slot_valid[g] = (CW'(g) < count_r);
      assign dup_hit[g]    = slot_valid[g] && (slot_prio_r[g] == prio_r);
      assign ins[g]        = !slot_valid[g] || (slot_prio_r[g] > prio_r);
      assign at_lo[g]      = slot_valid[g] && (slot_prio_r[g] >= lo_r);
      assign rng_hit[g]    = at_lo[g] && (slot_prio_r[g] < hi_r);

      if (g == 0) begin : g_first
        assign take_new[g] = ins[g];
        assign prev_prio   = '0;
        assign prev_elem   = '0;
      end else begin : g_inner
        assign take_new[g] = ins[g] && !ins[g-1];
        assign prev_prio   = slot_prio_r[g-1];
        assign prev_elem   = slot_elem_r[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign next_prio = slot_prio_r[g];
        assign next_elem = slot_elem_r[g];
      end else begin : g_body
        assign next_prio = slot_prio_r[g+1];
        assign next_elem = slot_elem_r[g+1];
      end

      // Enqueue opens a gap at the insertion point; range removal closes the
      // gap left by the lowest entry in range.
      always_ff @(posedge clk) begin
        if (enq_do && ins[g]) begin
          slot_prio_r[g] <= take_new[g] ? prio_r : prev_prio;
          slot_elem_r[g] <= take_new[g] ? elem_r : prev_elem;
        end else if (cmd.step && at_lo[g]) begin
          slot_prio_r[g] <= next_prio;
          slot_elem_r[g] <= next_elem;
        end
      end
    end
  endgenerate

  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign enq_do    = cmd.finish && (op_r == OP_ENQUEUE) && (prio_r != '0) && !full
                     && !(|dup_hit);
  assign deq_do    = cmd.finish && (op_r == OP_DEQUEUE) && (count_r != '0);
  assign count_dec = count_r - CW'(1);
  assign deq_idx   = count_dec[IW-1:0];

  assign sts.range_op  = (op_r == OP_REMOVE);
  assign sts.range_hit = |rng_hit;

  always_comb begin
    count_nxt   = count_r;
    removed_nxt = removed_r;
    op_ok       = 1'b0;
    res_elem    = '0;
    if (cmd.load) begin
      removed_nxt = 1'b0;
    end else if (cmd.step) begin
      count_nxt   = count_dec;
      removed_nxt = 1'b1;
    end else if (cmd.finish) begin
      case (op_r)
        OP_ENQUEUE: begin
          if (enq_do) begin
            count_nxt = count_r + CW'(1);
            op_ok     = 1'b1;
          end
        end
        OP_DEQUEUE: begin
          if (deq_do) begin
            count_nxt = count_dec;
            op_ok     = 1'b1;
            res_elem  = slot_elem_r[deq_idx];
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        OP_REMOVE: begin
          op_ok = removed_r;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      elem_r <= in_element;
      prio_r <= in_priority_req;
      lo_r   <= in_range_low;
      hi_r   <= in_range_high;
    end
    removed_r <= removed_nxt;
    if (cmd.finish) begin
      out_op_ok_r       <= op_ok;
      out_element_r     <= res_elem;
      out_entry_count_r <= count_nxt;
      out_queue_empty_r <= (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_op_ok       = out_op_ok_r;
  assign out_element     = out_element_r;
  assign out_entry_count = out_entry_count_r;
  assign out_queue_empty = out_queue_empty_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_step_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> (count_r == $past(count_dec)))
    else $error("range removal step did not drop exactly one entry");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_queue_empty_r == (out_entry_count_r == '0)))
    else $error("empty flag disagrees with entry count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(2)) |-> (slot_prio_r[0] < slot_prio_r[1]))
    else $error("lowest slots out of priority order");
`endif

endmodule

// ===== rtl/unique_priority_queue.sv =====
// ----------------------------------------------------------------------------
// unique_priority_queue: bounded priority queue with unique priorities
// The result strobe is registered when the run state finishes; a range removal
// first deletes the entries in its range, one per step.
// A new request is taken only once the last one has finished (busy low); the
// slot array removes at most one entry per step.
// Reset: synchronous and active low; the queue is empty at once, no clearing pass.
// ----------------------------------------------------------------------------
module unique_priority_queue
  import upq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int PRIO_BITS   = DEF_PRIO_BITS,
  parameter int ELEM_BITS   = DEF_ELEM_BITS
)
(
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [ELEM_BITS-1:0]               in_element,
  input  logic [PRIO_BITS-1:0]               in_priority_req,
  input  logic [PRIO_BITS-1:0]               in_range_low,
  input  logic [PRIO_BITS-1:0]               in_range_high,
  output logic                               out_valid,
  output logic                               out_op_ok,
  output logic [ELEM_BITS-1:0]               out_element,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_entry_count,
  output logic                               out_queue_empty
);

  // A request is taken when start is high while busy is low. The fields are
  // captured into the datapath and the controller moves to its run state,
  // which holds busy high. The result is registered in the final run cycle,
  // so its strobe appears in the same cycle that busy drops and the next
  // request may already be taken then.

  upq_cmd_t cmd;
  upq_sts_t sts;

  // The controller only sequences: it decides when to capture a request,
  // when to take another step of a range removal and when to finish.
  upq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the packed, ascending slot array. Enqueue compares
  // every slot with the new priority in parallel and shifts the upper part
  // up by one; a range removal deletes the lowest entry in the range on each
  // step, which works because the entries in range form one contiguous run.
  // Dequeue takes the top valid slot, which has the highest priority.
  upq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PRIO_BITS   (PRIO_BITS),
    .ELEM_BITS   (ELEM_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_element      (in_element),
    .in_priority_req (in_priority_req),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_op_ok       (out_op_ok),
    .out_element     (out_element),
    .out_entry_count (out_entry_count),
    .out_queue_empty (out_queue_empty)
  );

endmodule
